// File: hw/rtl/kmptt_pkg.sv
// ----------------------------------------------------------------------------
// kmptt_pkg: shared types and constants for the keyed max-priority task table
// Operation and status codes, table entry layout and controller/datapath links.
// ----------------------------------------------------------------------------
package kmptt_pkg;

  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_EDIT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_ABSENT = 3'd2,
    ST_FULL   = 3'd3,
    ST_DUP    = 3'd4
  } status_e;

  // one table row as stored in the entry memory
  typedef struct packed {
    logic        valid;
    logic [15:0] task_key;
    logic [15:0] owner;
    logic [31:0] prio;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch the incoming transaction, clear scan flags
    logic clr;     // write an empty row at the sweep counter
    logic rd;      // read the row at the sweep counter
    logic commit;  // apply the table update and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;  // sweep counter sits on the last row
    logic out_busy;  // result register full and not taken this cycle
  } sts_t;

endpackage

// File: hw/rtl/kmptt_ctrl.sv
// ----------------------------------------------------------------------------
// kmptt_ctrl: sequencing state machine
// Runs the post-reset clear sweep, then one full table scan per transaction.
// ----------------------------------------------------------------------------
module kmptt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kmptt_pkg::sts_t sts_i,
  output kmptt_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_LAST   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_LAST;
        end
      end
      // last read row is being evaluated
      S_LAST: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/kmptt_dp.sv
// ----------------------------------------------------------------------------
// kmptt_dp: table datapath
// Entry memory, sweep counter, scan trackers (key, free row, best row) and
// the result register.
// ----------------------------------------------------------------------------
module kmptt_dp #(
  parameter int unsigned DEPTH = kmptt_pkg::DefaultDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kmptt_pkg::cmd_t cmd_i,
  output kmptt_pkg::sts_t sts_o,
  input  logic [1:0]      operation_i,
  input  logic [15:0]     task_key_i,
  input  logic [15:0]     owner_i,
  input  logic [31:0]     prio_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     owner_out_o,
  output logic [2:0]      status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  // latched transaction
  kmptt_pkg::op_e op_q;
  logic [15:0]    key_q;
  logic [15:0]    own_q;
  logic [31:0]    prio_q;

  // memory and sweep
  kmptt_pkg::entry_t mem_q [DEPTH];
  kmptt_pkg::entry_t rdata_q;
  kmptt_pkg::entry_t wdata;
  logic [AW-1:0]     cnt_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     waddr;
  logic              we;
  logic              eval_q;
  logic              cnt_last;

  // scan trackers
  logic          key_found_q, free_found_q, best_found_q;
  logic [AW-1:0] key_slot_q, free_slot_q, best_slot_q;
  logic [15:0]   key_owner_q;
  logic [31:0]   best_prio_q;
  logic [15:0]   best_task_q;
  logic [15:0]   best_owner_q;
  logic          better;

  // result
  logic                out_valid_q;
  logic [15:0]         owner_out_q;
  kmptt_pkg::status_e  status_q;
  logic [15:0]         res_owner;
  kmptt_pkg::status_e  res_status;
  logic                upd_we;
  logic [AW-1:0]       upd_addr;
  kmptt_pkg::entry_t   upd_data;

  assign cnt_last       = (cnt_q == LastIdx);
  assign sts_o.cnt_last = cnt_last;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      eval_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.rd;
      if (cmd_i.clr || cmd_i.rd) begin
        cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= cnt_q;
    if (cmd_i.start) begin
      op_q   <= kmptt_pkg::op_e'(operation_i);
      key_q  <= task_key_i;
      own_q  <= owner_i;
      prio_q <= prio_i;
    end
  end

  // single-port style memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[cnt_q];
    end
  end

  // highest priority wins, ties go to the higher task key
  assign better = !best_found_q
               || ($signed(rdata_q.prio) > $signed(best_prio_q))
               || ((rdata_q.prio == best_prio_q) && (rdata_q.task_key > best_task_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else if (cmd_i.start) begin
      key_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else if (eval_q) begin
      if (rdata_q.valid && (rdata_q.task_key == key_q) && !key_found_q) begin
        key_found_q <= 1'b1;
      end
      if (!rdata_q.valid && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      if (rdata_q.valid && better) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_q) begin
      if (rdata_q.valid && (rdata_q.task_key == key_q) && !key_found_q) begin
        key_slot_q  <= idx_q;
        key_owner_q <= rdata_q.owner;
      end
      if (!rdata_q.valid && !free_found_q) begin
        free_slot_q <= idx_q;
      end
      if (rdata_q.valid && better) begin
        best_slot_q  <= idx_q;
        best_prio_q  <= rdata_q.prio;
        best_task_q  <= rdata_q.task_key;
        best_owner_q <= rdata_q.owner;
      end
    end
  end

  // outcome of the scan
  always_comb begin
    res_owner  = '0;
    res_status = kmptt_pkg::ST_OK;
    upd_we     = 1'b0;
    upd_addr   = key_slot_q;
    upd_data   = '{valid: 1'b0, task_key: key_q, owner: own_q, prio: prio_q};
    case (op_q)
      kmptt_pkg::OP_ADD: begin
        if (key_found_q) begin
          res_status = kmptt_pkg::ST_DUP;
        end else if (!free_found_q) begin
          res_status = kmptt_pkg::ST_FULL;
        end else begin
          upd_we         = 1'b1;
          upd_addr       = free_slot_q;
          upd_data.valid = 1'b1;
        end
      end
      kmptt_pkg::OP_EDIT: begin
        if (!key_found_q) begin
          res_status = kmptt_pkg::ST_ABSENT;
        end else begin
          upd_we         = 1'b1;
          upd_data.valid = 1'b1;
          upd_data.owner = key_owner_q;
        end
      end
      kmptt_pkg::OP_REMOVE: begin
        if (!key_found_q) begin
          res_status = kmptt_pkg::ST_ABSENT;
        end else begin
          upd_we = 1'b1;
        end
      end
      kmptt_pkg::OP_POP: begin
        if (!best_found_q) begin
          res_status = kmptt_pkg::ST_EMPTY;
        end else begin
          res_owner = best_owner_q;
          upd_we    = 1'b1;
          upd_addr  = best_slot_q;
        end
      end
      default: begin
        res_status = kmptt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    if (cmd_i.clr) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else begin
      we    = cmd_i.commit && upd_we;
      waddr = upd_addr;
      wdata = upd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      owner_out_q <= res_owner;
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign owner_out_o = owner_out_q;
  assign status_o    = status_q;

endmodule

// File: hw/rtl/keyed_max_priority_task_table.sv
// A new transaction is taken only after the previous one has been committed,
//   since each one is a row-by-row scan over the single-port entry memory.
// Reset: asynchronous, active low. After reset a clear sweep marks every row
//   empty; in_ready_o stays low until it is done.
// ----------------------------------------------------------------------------
// keyed_max_priority_task_table: keyed max-priority task table
// Holds up to DEPTH tasks (key, owner, signed priority). Supports add, edit
// priority, remove and pop-highest, each answered by one result transaction.
// ----------------------------------------------------------------------------
module keyed_max_priority_task_table #(
  parameter int unsigned DEPTH = kmptt_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transaction
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] task_key_i,
  input  logic [15:0] owner_i,
  input  logic [31:0] prio_i,
  // result transaction
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] owner_out_o,
  output logic [2:0]  status_o
);

  // Each transaction is latched, then every row is read once. While scanning,
  // the datapath tracks the first row matching the key, the lowest free row
  // and the best row (highest priority, ties to higher key). One write then
  // applies the update and the result lands in an output register, so a new
  // transaction can be taken while the previous result is still waiting.

  kmptt_pkg::cmd_t cmd;
  kmptt_pkg::sts_t sts;

  kmptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmptt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .task_key_i  (task_key_i),
    .owner_i     (owner_i),
    .prio_i      (prio_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .owner_out_o (owner_out_o),
    .status_o    (status_o)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: keyed max-priority task table
// Drives add, edit, remove and pop transactions through the valid/ready
// input channel and checks each result against an in-bench table model.
// A directed table runs first, then a random part made of fill, churn and
// drain rounds. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import kmptt_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int unsigned NumItems   = 1350;
  localparam int unsigned CycleLimit = 1_000_000;
  // wait well past one full transaction for stray results at the end
  localparam int unsigned DrainWait  = 2 * Depth + 8;

  // one result transaction as the table model predicts it
  typedef struct packed {
    logic [15:0] owner;
    status_e     status;
  } answer_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    op_e         op;
    logic [15:0] key;
    logic [15:0] owner;
    logic [31:0] prio;
    logic        typed;
    logic [15:0] exp_owner;
    status_e     exp_status;
  } dir_row_t;

  // flavor of a random round
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } mix_e;

  // Directed stimulus: empty pop, absent keys, duplicate add, priority
  // extremes, ties broken by the higher key, ignored fields on pop/remove.
  localparam dir_row_t DirRows [22] = '{
    '{OP_POP,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_EMPTY },
    '{OP_EDIT,   16'h0005, 16'h0000, 32'h0000_0007, 1'b1, 16'h0000, ST_ABSENT},
    '{OP_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_ABSENT},
    '{OP_ADD,    16'h0000, 16'hFFFF, 32'h8000_0000, 1'b1, 16'h0000, ST_OK    },
    '{OP_ADD,    16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 1'b1, 16'h0000, ST_OK    },
    '{OP_ADD,    16'h0000, 16'h1234, 32'h0000_0000, 1'b1, 16'h0000, ST_DUP   },
    '{OP_ADD,    16'h1234, 16'hAAAA, 32'h7FFF_FFFF, 1'b1, 16'h0000, ST_OK    },
    '{OP_POP,    16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 16'h0000, ST_OK    },
    '{OP_POP,    16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 16'h0000, ST_OK    },
    '{OP_EDIT,   16'h0000, 16'h5A5A, 32'h0000_0000, 1'b1, 16'h0000, ST_OK    },
    '{OP_ADD,    16'h5555, 16'h5555, 32'hFFFF_FFFF, 1'b1, 16'h0000, ST_OK    },
    '{OP_ADD,    16'h8000, 16'h0001, 32'hFFFF_FFFF, 1'b1, 16'h0000, ST_OK    },
    '{OP_POP,    16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 16'h0000, ST_OK    },
    '{OP_POP,    16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 16'h0000, ST_OK    },
    '{OP_REMOVE, 16'h5555, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_OK    },
    '{OP_REMOVE, 16'h5555, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_ABSENT},
    '{OP_EDIT,   16'h5555, 16'h0000, 32'h0000_0001, 1'b1, 16'h0000, ST_ABSENT},
    '{OP_POP,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000, ST_EMPTY },
    '{OP_ADD,    16'h7FFF, 16'h8000, 32'h8000_0001, 1'b1, 16'h0000, ST_OK    },
    '{OP_POP,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0000, ST_OK    },
    '{OP_REMOVE, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 16'h0000, ST_ABSENT},
    '{OP_POP,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_EMPTY }
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [15:0] task_key_i;
  logic [15:0] owner_i;
  logic [31:0] prio_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] owner_out_o;
  logic [2:0]  status_o;

  keyed_max_priority_task_table #(
    .DEPTH(Depth)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .task_key_i  (task_key_i),
    .owner_i     (owner_i),
    .prio_i      (prio_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .owner_out_o (owner_out_o),
    .status_o    (status_o)
  );

  // Table model: its own copy of the rows, updated when a transaction is
  // accepted, so the block's in-order processing keeps it aligned.
  logic        tbl_valid [Depth];
  logic [15:0] tbl_key   [Depth];
  logic [15:0] tbl_owner [Depth];
  logic [31:0] tbl_prio  [Depth];
  int unsigned tbl_used;

  answer_t     pending_results [$];
  int unsigned mismatches;
  int unsigned n_sent;
  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned rx_left;
  logic        rx_open;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // row holding the key, -1 when absent
  function automatic int find_key(logic [15:0] key);
    for (int i = 0; i < Depth; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  // lowest free row, -1 when full
  function automatic int find_free();
    for (int i = 0; i < Depth; i++) begin
      if (!tbl_valid[i]) return i;
    end
    return -1;
  endfunction

  // highest signed priority wins; a tie goes to the higher key
  function automatic int find_top();
    int best;
    best = -1;
    for (int i = 0; i < Depth; i++) begin
      if (tbl_valid[i]) begin
        if (best < 0) begin
          best = i;
        end else if ($signed(tbl_prio[i]) > $signed(tbl_prio[best]) ||
                     (tbl_prio[i] == tbl_prio[best] && tbl_key[i] > tbl_key[best])) begin
          best = i;
        end
      end
    end
    return best;
  endfunction

  // apply one operation to the model and return the result it gives
  function automatic answer_t apply_to_table(op_e op, logic [15:0] key, logic [15:0] owner,
                                             logic [31:0] prio);
    answer_t ans;
    int      slot;
    ans.owner  = '0;
    ans.status = ST_OK;
    case (op)
      OP_ADD: begin
        // duplicate check comes before the full check
        if (find_key(key) >= 0) begin
          ans.status = ST_DUP;
        end else begin
          slot = find_free();
          if (slot < 0) begin
            ans.status = ST_FULL;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = key;
            tbl_owner[slot] = owner;
            tbl_prio[slot]  = prio;
            tbl_used++;
          end
        end
      end
      OP_EDIT: begin
        slot = find_key(key);
        if (slot < 0) ans.status = ST_ABSENT;
        else tbl_prio[slot] = prio;
      end
      OP_REMOVE: begin
        slot = find_key(key);
        if (slot < 0) begin
          ans.status = ST_ABSENT;
        end else begin
          tbl_valid[slot] = 1'b0;
          tbl_used--;
        end
      end
      default: begin
        slot = find_top();
        if (slot < 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.owner       = tbl_owner[slot];
          tbl_valid[slot] = 1'b0;
          tbl_used--;
        end
      end
    endcase
    return ans;
  endfunction

  // key of some live task, or a random one when the table is empty
  function automatic logic [15:0] live_key();
    int start;
    start = $urandom_range(0, Depth - 1);
    for (int n = 0; n < Depth; n++) begin
      if (tbl_valid[(start + n) % Depth]) return tbl_key[(start + n) % Depth];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // full-range values, a narrow band for ties, and the extremes
  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 4))
      0, 1: return $urandom();
      2, 3: return 32'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h8000_0001;
          default: return 32'h7FFF_FFFE;
        endcase
      end
    endcase
  endfunction

  // Present one transaction, wait for the handshake, then book the result.
  // The sender works in bursts; a zero gap keeps valid high across bursts.
  task automatic send_op(op_e op, logic [15:0] key, logic [15:0] owner, logic [31:0] prio,
                         logic typed, answer_t typed_ans);
    answer_t     ans;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    task_key_i  <= key;
    owner_i     <= owner;
    prio_i      <= prio;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    // the model always moves; typed rows replace only the expected answer
    ans = apply_to_table(op, key, owner, prio);
    if (typed) ans = typed_ans;
    pending_results.insert(pending_results.size(), ans);
    n_sent++;
  endtask

  // Draw one random transaction; the round's flavor sets the operation mix.
  task automatic pick_item(input mix_e mix, output op_e op, output logic [15:0] key,
                           output logic [15:0] owner, output logic [31:0] prio);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  op = (roll < 85) ? OP_ADD : (roll < 95) ? OP_EDIT :
                      (roll < 98) ? OP_REMOVE : OP_POP;
      MIX_CHURN: op = (roll < 30) ? OP_ADD : (roll < 55) ? OP_EDIT :
                      (roll < 75) ? OP_REMOVE : OP_POP;
      default:   op = (roll < 5) ? OP_ADD : (roll < 10) ? OP_EDIT :
                      (roll < 40) ? OP_REMOVE : OP_POP;
    endcase
    // adds mostly use fresh keys; edits and removes mostly hit live ones
    case (op)
      OP_ADD:  key = ($urandom_range(0, 4) == 0) ? live_key() : 16'($urandom_range(0, 65535));
      OP_POP:  key = 16'($urandom_range(0, 65535));
      default: key = ($urandom_range(0, 4) != 0) ? live_key() : 16'($urandom_range(0, 65535));
    endcase
    owner = 16'($urandom_range(0, 65535));
    prio  = rand_prio();
  endtask

  // Receiver: alternating open and stalled stretches of random length,
  // now and then a long open stretch with no stalls at all.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_open = !rx_open;
      if (rx_open) begin
        rx_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 120);
      end else begin
        rx_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 70);
      end
    end
    rx_left--;
    out_ready_i <= rx_open;
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: owner_out %h status %0d", owner_out_o, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (owner_out_o !== want.owner) begin
          $error("owner_out: expected %h, actual %h", want.owner, owner_out_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: the slowest legal run stays far below this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    answer_t     typed_ans;
    op_e         op;
    logic [15:0] key;
    logic [15:0] owner;
    logic [31:0] prio;
    mix_e        mix;
    int          round_left;
    int unsigned roll;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_ADD;
    task_key_i  <= '0;
    owner_i     <= '0;
    prio_i      <= '0;
    out_ready_i <= 1'b0;
    rx_open     = 1'b0;
    rx_left     = 0;
    burst_left  = 0;
    n_sent      = 0;
    mismatches  = 0;
    cycle_count = 0;
    tbl_used    = 0;
    for (int i = 0; i < Depth; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_owner[i] = '0;
      tbl_prio[i]  = '0;
    end

    // single reset; the block's clear sweep holds in_ready_o low afterwards
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (DirRows[i]) begin
      typed_ans.owner  = DirRows[i].exp_owner;
      typed_ans.status = DirRows[i].exp_status;
      send_op(DirRows[i].op, DirRows[i].key, DirRows[i].owner, DirRows[i].prio,
              DirRows[i].typed, typed_ans);
    end

    // Random rounds. The first fills the table to full; fill rounds then
    // push a few adds past full, drain rounds a few pops past empty.
    typed_ans  = '0;
    mix        = MIX_FILL;
    round_left = 400;
    while (n_sent < NumItems) begin
      pick_item(mix, op, key, owner, prio);
      send_op(op, key, owner, prio, 1'b0, typed_ans);
      round_left--;
      if (mix == MIX_FILL && tbl_used == Depth && round_left > 6) begin
        round_left = $urandom_range(2, 6);
      end
      if (mix == MIX_DRAIN && tbl_used == 0 && round_left > 3) begin
        round_left = $urandom_range(1, 3);
      end
      if (round_left <= 0) begin
        roll = $urandom_range(0, 9);
        mix  = (roll < 3) ? MIX_FILL : (roll < 7) ? MIX_CHURN : MIX_DRAIN;
        round_left = (mix == MIX_CHURN) ? $urandom_range(20, 80) : 400;
      end
    end
    in_valid_i <= 1'b0;

    // let every booked result arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/kmptt_pkg.sv
hw/rtl/kmptt_ctrl.sv
hw/rtl/kmptt_dp.sv
hw/rtl/keyed_max_priority_task_table.sv
test/testbench.sv
